### rtl/rfpd_pkg.sv
// Package for the ranging frame pass detector.
// Holds shared types, codes and constants; no dependencies.
package rfpd_pkg;

    localparam logic [7:0]  HEADER_BYTE = 8'hA5;
    localparam logic [15:0] TIMER_SCALE = 16'd200;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_APPROACH_DELTA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXIT_DELAY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HANDOFF_DELAY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_SECONDS  = 3'd5;

    localparam logic [15:0] RST_NEAR_LIMIT     = 16'd2000;
    localparam logic [15:0] RST_APPROACH_DELTA = 16'd100;
    localparam logic [7:0]  RST_CONFIRM_COUNT  = 8'd5;
    localparam logic [7:0]  RST_EXIT_DELAY     = 8'd2;
    localparam logic [7:0]  RST_HANDOFF_DELAY  = 8'd25;
    localparam logic [7:0]  RST_TIMER_SECONDS  = 8'd10;

    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_HIGH   = 2'd1,
        POS_LOW    = 2'd2
    } frame_pos_t;

    typedef struct packed {
        logic [15:0] near_limit;
        logic [15:0] approach_delta;
        logic [7:0]  confirm_count;
        logic [7:0]  exit_delay;
        logic [7:0]  handoff_delay;
        logic [7:0]  timer_seconds;
    } cfg_t;

    typedef struct packed {
        logic [15:0] distance;
        logic        other_car_at_start;
    } frame_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

### rtl/rfpd_front.sv
// Frame assembler: collects header, high and low bytes into one frame.
// Depends on rfpd_pkg.
module rfpd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_ready,
    input  logic [7:0]          rx_byte,
    input  logic                other_car_at_start,
    output logic                push,
    input  logic                q_full,
    output rfpd_pkg::frame_t    frame
);

    rfpd_pkg::frame_pos_t pos_reg;
    rfpd_pkg::frame_pos_t pos_next;
    logic [7:0]           high_reg;
    logic [7:0]           high_next;
    logic                 take;

    assign take = rx_valid && rx_ready;

    always_comb
    begin
        pos_next  = pos_reg;
        high_next = high_reg;
        unique case (pos_reg)
            rfpd_pkg::POS_HIGH:
            begin
                if (take)
                begin
                    high_next = rx_byte;
                    pos_next  = rfpd_pkg::POS_LOW;
                end
            end
            rfpd_pkg::POS_LOW:
            begin
                if (take)
                begin
                    pos_next = rfpd_pkg::POS_HEADER;
                end
            end
            default:
            begin
                if (take)
                begin
                    pos_next = (rx_byte == rfpd_pkg::HEADER_BYTE) ?
                               rfpd_pkg::POS_HIGH : rfpd_pkg::POS_HEADER;
                end
            end
        endcase
    end

    always_comb
    begin
        rx_ready = 1'b1;
        push     = 1'b0;
        unique case (pos_reg)
            rfpd_pkg::POS_LOW:
            begin
                rx_ready = !q_full;
                push     = rx_valid && !q_full;
            end
            default:
            begin
                rx_ready = 1'b1;
                push     = 1'b0;
            end
        endcase
    end

    assign frame.distance           = {high_reg, rx_byte};
    assign frame.other_car_at_start = other_car_at_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= rfpd_pkg::POS_HEADER;
            high_reg <= 8'd0;
        end
        else
        begin
            pos_reg  <= pos_next;
            high_reg <= high_next;
        end
    end

endmodule

### rtl/rfpd_queue.sv
// Short frame queue between assembler and detector.
// Depends on rfpd_pkg.
module rfpd_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rfpd_pkg::frame_t    push_frame,
    output logic                full,
    output rfpd_pkg::hs_t       pop_hs,
    input  logic                pop_take,
    output rfpd_pkg::frame_t    pop_frame
);

    rfpd_pkg::frame_t              entry_reg [rfpd_pkg::QDEPTH];
    logic [rfpd_pkg::QAW-1:0]      wr_ptr_reg;
    logic [rfpd_pkg::QAW-1:0]      rd_ptr_reg;
    logic [rfpd_pkg::QAW:0]        count_reg;
    logic [rfpd_pkg::QAW:0]        count_next;
    logic                          pop;

    assign full         = (count_reg == (rfpd_pkg::QAW+1)'(rfpd_pkg::QDEPTH));
    assign pop_hs.valid = (count_reg != '0);
    assign pop_hs.ready = pop_take;
    assign pop          = pop_hs.valid && pop_take;
    assign pop_frame    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

### rtl/rfpd_back.sv
// Pass detector: updates near, exit and handoff state per frame, registers the result.
// Depends on rfpd_pkg.
module rfpd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  rfpd_pkg::cfg_t      cfg,
    input  rfpd_pkg::hs_t       q_hs,
    output logic                q_take,
    input  rfpd_pkg::frame_t    q_frame,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [15:0]         distance,
    output logic                car_near,
    output logic                handoff_given,
    output logic [7:0]          pass_count,
    output logic                timer_load,
    output logic [15:0]         timer_value
);

    logic [15:0] last_dist_reg;
    logic [7:0]  confirm_reg, confirm_next;
    logic        near_flag_reg, near_flag_next;
    logic        exit_pend_reg, exit_pend_next;
    logic [7:0]  exit_cnt_reg, exit_cnt_next;
    logic [7:0]  passes_reg, passes_next;
    logic        hoff_pend_reg, hoff_pend_next;
    logic [7:0]  hoff_cnt_reg, hoff_cnt_next;
    logic        hoff_flag_reg, hoff_flag_next;

    logic        out_valid_reg;
    logic [15:0] out_dist_reg;
    logic        out_near_reg;
    logic        out_hoff_reg;
    logic [7:0]  out_pass_reg;
    logic        out_tload_reg, tload_next;
    logic [15:0] out_tval_reg, tval_next;

    logic                fire;
    logic [15:0]         cur_dist;
    logic signed [16:0]  rise;
    logic                near;
    logic                ep1, ep2, cn1, start_exit, exit_done, hp2, hoff_done;
    logic [7:0]          ec1, hc1;
    logic [15:0]         timer_prod;

    assign q_take = !out_valid_reg || res_ready;
    assign fire   = q_hs.valid && q_hs.ready;
    assign cur_dist = q_frame.distance;
    assign rise   = $signed({1'b0, cur_dist}) - $signed({1'b0, last_dist_reg});
    assign near   = (cur_dist <= cfg.near_limit) &&
                    (rise <= $signed({1'b0, cfg.approach_delta}));
    assign timer_prod = {8'd0, cfg.timer_seconds} * rfpd_pkg::TIMER_SCALE;

    always_comb
    begin
        confirm_next   = near ? ((confirm_reg == 8'hFF) ? confirm_reg : confirm_reg + 8'd1)
                              : 8'd0;
        ep1            = near ? 1'b0 : exit_pend_reg;
        cn1            = (near && (confirm_next >= cfg.confirm_count)) ? 1'b1 : near_flag_reg;
        start_exit     = (cur_dist >= cfg.near_limit) && cn1 && !ep1;
        ep2            = start_exit ? 1'b1 : ep1;
        ec1            = start_exit ? cfg.exit_delay : exit_cnt_reg;
        exit_done      = ep2 && (ec1 <= 8'd1);
        exit_cnt_next  = ep2 ? (exit_done ? 8'd0 : ec1 - 8'd1) : ec1;
        exit_pend_next = exit_done ? 1'b0 : ep2;
        near_flag_next = exit_done ? 1'b0 : cn1;
        passes_next    = passes_reg;
        tload_next     = 1'b0;
        tval_next      = 16'd0;
        hp2            = hoff_pend_reg;
        hc1            = hoff_cnt_reg;
        if (exit_done)
        begin
            if (passes_reg != 8'hFF)
            begin
                passes_next = passes_reg + 8'd1;
                if (passes_reg == 8'd0)
                begin
                    tload_next = 1'b1;
                    tval_next  = timer_prod;
                end
            end
            if (q_frame.other_car_at_start && !hoff_pend_reg)
            begin
                hc1 = cfg.handoff_delay;
                hp2 = 1'b1;
            end
        end
        hoff_done      = hp2 && (hc1 <= 8'd1);
        hoff_cnt_next  = hp2 ? (hoff_done ? 8'd0 : hc1 - 8'd1) : hc1;
        hoff_pend_next = hoff_done ? 1'b0 : hp2;
        hoff_flag_next = hoff_flag_reg || hoff_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_dist_reg <= 16'd0;
            confirm_reg   <= 8'd0;
            near_flag_reg <= 1'b0;
            exit_pend_reg <= 1'b0;
            exit_cnt_reg  <= 8'd0;
            passes_reg    <= 8'd0;
            hoff_pend_reg <= 1'b0;
            hoff_cnt_reg  <= 8'd0;
            hoff_flag_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                last_dist_reg <= cur_dist;
                confirm_reg   <= confirm_next;
                near_flag_reg <= near_flag_next;
                exit_pend_reg <= exit_pend_next;
                exit_cnt_reg  <= exit_cnt_next;
                passes_reg    <= passes_next;
                hoff_pend_reg <= hoff_pend_next;
                hoff_cnt_reg  <= hoff_cnt_next;
                hoff_flag_reg <= hoff_flag_next;
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_dist_reg  <= cur_dist;
            out_near_reg  <= near_flag_next;
            out_hoff_reg  <= hoff_flag_next;
            out_pass_reg  <= passes_next;
            out_tload_reg <= tload_next;
            out_tval_reg  <= tval_next;
        end
    end

    assign res_valid     = out_valid_reg;
    assign distance      = out_dist_reg;
    assign car_near      = out_near_reg;
    assign handoff_given = out_hoff_reg;
    assign pass_count    = out_pass_reg;
    assign timer_load    = out_tload_reg;
    assign timer_value   = out_tval_reg;

endmodule

### rtl/ranging_frame_pass_detector_top.sv
// Top level of the ranging frame pass detector: config registers, assembler,
// frame queue and pass detector. Depends on rfpd_pkg and the rfpd_* modules.
// Throughput: one byte per cycle; a full queue stalls only the low byte.
// Path: a frame's low byte is written into the two-entry queue; the detector
// pops it when its result register is free and registers the result there.
// Reset: asynchronous, active low; clears control state, loads register defaults.
module ranging_frame_pass_detector_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rfpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rfpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              rx_valid,
    output logic                              rx_ready,
    input  logic [7:0]                        rx_byte,
    input  logic                              other_car_at_start,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [15:0]                       distance,
    output logic                              car_near,
    output logic                              handoff_given,
    output logic [7:0]                        pass_count,
    output logic                              timer_load,
    output logic [15:0]                       timer_value
);

    rfpd_pkg::cfg_t   cfg_reg;
    rfpd_pkg::cfg_t   cfg_next;
    rfpd_pkg::frame_t push_frame;
    rfpd_pkg::frame_t pop_frame;
    rfpd_pkg::hs_t    pop_hs;
    logic             push;
    logic             q_full;
    logic             q_take;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                rfpd_pkg::REG_NEAR_LIMIT:     cfg_next.near_limit     = cfg_data;
                rfpd_pkg::REG_APPROACH_DELTA: cfg_next.approach_delta = cfg_data;
                rfpd_pkg::REG_CONFIRM_COUNT:  cfg_next.confirm_count  = cfg_data[7:0];
                rfpd_pkg::REG_EXIT_DELAY:     cfg_next.exit_delay     = cfg_data[7:0];
                rfpd_pkg::REG_HANDOFF_DELAY:  cfg_next.handoff_delay  = cfg_data[7:0];
                rfpd_pkg::REG_TIMER_SECONDS:  cfg_next.timer_seconds  = cfg_data[7:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_limit     <= rfpd_pkg::RST_NEAR_LIMIT;
            cfg_reg.approach_delta <= rfpd_pkg::RST_APPROACH_DELTA;
            cfg_reg.confirm_count  <= rfpd_pkg::RST_CONFIRM_COUNT;
            cfg_reg.exit_delay     <= rfpd_pkg::RST_EXIT_DELAY;
            cfg_reg.handoff_delay  <= rfpd_pkg::RST_HANDOFF_DELAY;
            cfg_reg.timer_seconds  <= rfpd_pkg::RST_TIMER_SECONDS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rfpd_front u_front
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .rx_valid           (rx_valid),
        .rx_ready           (rx_ready),
        .rx_byte            (rx_byte),
        .other_car_at_start (other_car_at_start),
        .push               (push),
        .q_full             (q_full),
        .frame              (push_frame)
    );

    rfpd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (q_full),
        .pop_hs     (pop_hs),
        .pop_take   (q_take),
        .pop_frame  (pop_frame)
    );

    rfpd_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_hs          (pop_hs),
        .q_take        (q_take),
        .q_frame       (pop_frame),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .distance      (distance),
        .car_near      (car_near),
        .handoff_given (handoff_given),
        .pass_count    (pass_count),
        .timer_load    (timer_load),
        .timer_value   (timer_value)
    );

endmodule
